/* rtl/bft_pkg.sv */
// Shared types and constants for the boundary face table.
// No dependencies; imported by every module of the block.
package bft_pkg;

   localparam int TableDepthDefault = 1024;
   localparam int VertexBitsDefault = 20;
   localparam int FieldBits         = 20;
   localparam int CountBits         = 11;
   localparam int HitBits           = 4;
   localparam int IndexBits         = 10;

   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_ADD   = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_OOR  = 2'd2;

   typedef struct packed {
      logic [1:0]           command;
      logic [FieldBits-1:0] corner_a;
      logic [FieldBits-1:0] corner_b;
      logic [FieldBits-1:0] corner_c;
      logic [FieldBits-1:0] corner_d;
      logic                 left_hand;
      logic [IndexBits-1:0] entry_index;
   } req_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [FieldBits-1:0] face_low;
      logic [FieldBits-1:0] face_mid;
      logic [FieldBits-1:0] face_high;
      logic                 flipped;
      logic [HitBits-1:0]   hit_count;
      logic                 is_boundary;
      logic [CountBits-1:0] entries_used;
      logic [CountBits-1:0] boundary_total;
   } rsp_type;

   // One sorted face with its flip mark.
   typedef struct packed {
      logic [FieldBits-1:0] lo;
      logic [FieldBits-1:0] mid;
      logic [FieldBits-1:0] hi;
      logic                 flip;
   } face_type;

   // Classified work word handed from front to back.
   typedef struct packed {
      logic [1:0]           command;
      face_type [3:0]       faces;
      logic [IndexBits-1:0] entry_index;
   } job_type;

   // Three-element bubble sort matching the face ordering rule; swaps on equal.
   function automatic face_type sort_face(input logic [FieldBits-1:0] p,
                                          input logic [FieldBits-1:0] q,
                                          input logic [FieldBits-1:0] r,
                                          input logic hand);
      logic [FieldBits-1:0] v0, v1, v2, t;
      logic par;
      face_type f;
      v0 = p; v1 = q; v2 = r; par = hand;
      if (!(v0 < v1)) begin t = v0; v0 = v1; v1 = t; par = ~par; end
      if (!(v1 < v2)) begin t = v1; v1 = v2; v2 = t; par = ~par; end
      if (!(v0 < v1)) begin t = v0; v0 = v1; v1 = t; par = ~par; end
      f.lo = v0; f.mid = v1; f.hi = v2; f.flip = par;
      return f;
   endfunction

endpackage

/* rtl/boundary_face_table.sv */
// Top level of the boundary face table: front end, job queue and table engine.
// Depends on bft_pkg, bft_front and bft_back.
//
// Each request word is one command: clear, add a tetrahedron, or read an entry.
// The front end sorts the four faces and queues up to two words, so requests
// are taken while the table engine works. The engine searches the face table
// linearly through one memory port, one stored entry after another, so an add
// takes longer as the table fills; a read and a clear do no search. Exactly one
// response word is produced per request, in order.
module boundary_face_table #(
   parameter int TABLE_DEPTH = bft_pkg::TableDepthDefault,
   parameter int VERTEX_BITS = bft_pkg::VertexBitsDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  bft_pkg::req_type req_data,
   output logic             empty,
   input  logic             pop,
   output bft_pkg::rsp_type rsp_data
);
   import bft_pkg::*;

   logic    job_valid, job_take;
   job_type job_data;

   bft_front #(.VERTEX_BITS(VERTEX_BITS)) u_front (
      .clock, .reset,
      .req_push(push), .req_full(full), .req_data,
      .job_valid, .job_take, .job_data
   );

   bft_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
      .clock, .reset,
      .job_valid, .job_take, .job_data,
      .rsp_empty(empty), .rsp_pop(pop), .rsp_data
   );

endmodule

/* rtl/bft_front.sv */
// Front end: accepts request words, forms and sorts the four faces,
// and queues classified jobs. Depends on bft_pkg.
module bft_front #(
   parameter int VERTEX_BITS = bft_pkg::VertexBitsDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  bft_pkg::req_type req_data,
   output logic             job_valid,
   input  logic             job_take,
   output bft_pkg::job_type job_data
);
   import bft_pkg::*;

   localparam int QDepth = 2;

   job_type              q_ff [QDepth];
   logic                 wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]           cnt_ff, cnt_in;
   job_type              job_new;
   logic [FieldBits-1:0] a, b, c, d;
   logic                 do_push, do_pop;

   localparam logic [FieldBits-1:0] VMask = FieldBits'((64'd1 << VERTEX_BITS) - 64'd1);

   always_comb begin
      a = req_data.corner_a & VMask;
      b = req_data.corner_b & VMask;
      c = req_data.corner_c & VMask;
      d = req_data.corner_d & VMask;
      job_new.command     = req_data.command;
      job_new.entry_index = req_data.entry_index;
      job_new.faces[0]    = sort_face(d, c, b, req_data.left_hand);
      job_new.faces[1]    = sort_face(a, c, d, req_data.left_hand);
      job_new.faces[2]    = sort_face(a, d, b, req_data.left_hand);
      job_new.faces[3]    = sort_face(a, b, c, req_data.left_hand);
   end

   assign req_full  = (cnt_ff == 2'(QDepth));
   assign job_valid = (cnt_ff != 2'd0);
   assign job_data  = q_ff[rp_ff];
   assign do_push   = req_push && !req_full;
   assign do_pop    = job_take && job_valid;

   always_comb begin
      wp_in  = do_push ? ~wp_ff : wp_ff;
      rp_in  = do_pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) q_ff[wp_ff] <= job_new;
   end

endmodule

/* rtl/bft_back.sv */
// Back end: takes one job at a time, searches and updates the face table one
// entry after another and holds each result word until it is popped. Depends on bft_pkg.
module bft_back #(
   parameter int TABLE_DEPTH = bft_pkg::TableDepthDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   output logic             job_take,
   input  bft_pkg::job_type job_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output bft_pkg::rsp_type rsp_data
);
   import bft_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int LW = $clog2(TABLE_DEPTH + 1);
   localparam int VW = 3 * FieldBits;

   typedef enum logic [2:0] {
      S_IDLE, S_PROBE, S_CHECK, S_NEXT, S_RDWAIT, S_RDOUT, S_EMIT
   } state_type;

   logic [VW-1:0]      vert_mem [TABLE_DEPTH];
   logic [HitBits:0]   mark_mem [TABLE_DEPTH];

   state_type          st_ff;
   job_type            job_ff;
   logic [1:0]         face_ff;
   logic [LW-1:0]      scan_ff;
   logic [LW-1:0]      fill_ff;
   logic [LW-1:0]      bnd_ff;
   logic [VW-1:0]      vrd_ff;
   logic [HitBits:0]   mrd_ff;
   logic [AW-1:0]      raddr;
   logic               rsp_full_ff;
   rsp_type            rsp_ff;
   logic [1:0]         stat_ff;
   face_type           cur;
   logic [HitBits-1:0] cnt_cur;
   logic               emit_go;

   assign cur      = job_ff.faces[face_ff];
   assign cnt_cur  = mrd_ff[HitBits-1:0];
   assign job_take = (st_ff == S_IDLE) && job_valid;
   assign rsp_empty = !rsp_full_ff;
   assign rsp_data  = rsp_ff;
   assign raddr     = scan_ff[AW-1:0];
   assign emit_go   = (st_ff == S_EMIT) && (!rsp_full_ff || rsp_pop);

   always_ff @(posedge clock) begin
      vrd_ff <= vert_mem[raddr];
      mrd_ff <= mark_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff       <= S_IDLE;
         fill_ff     <= '0;
         bnd_ff      <= '0;
         rsp_full_ff <= 1'b0;
         face_ff     <= '0;
         scan_ff     <= '0;
         stat_ff     <= ST_OK;
      end else begin
         if (emit_go) rsp_full_ff <= 1'b1;
         else if (rsp_pop && rsp_full_ff) rsp_full_ff <= 1'b0;
         case (st_ff)
            S_IDLE: begin
               if (job_valid) begin
                  job_ff  <= job_data;
                  face_ff <= '0;
                  scan_ff <= '0;
                  stat_ff <= ST_OK;
                  case (job_data.command)
                     CMD_CLEAR: begin
                        fill_ff <= '0;
                        bnd_ff  <= '0;
                        st_ff   <= S_EMIT;
                     end
                     CMD_ADD: st_ff <= S_PROBE;
                     CMD_READ: begin
                        if (LW'(job_data.entry_index) >= fill_ff ||
                            32'(job_data.entry_index) >= TABLE_DEPTH) begin
                           stat_ff <= ST_OOR;
                           st_ff   <= S_EMIT;
                        end else begin
                           scan_ff <= LW'(job_data.entry_index);
                           st_ff   <= S_RDWAIT;
                        end
                     end
                     default: st_ff <= S_EMIT;
                  endcase
               end
            end
            S_PROBE: begin
               // scan_ff addresses the memory; data arrives next cycle
               if (scan_ff >= fill_ff) begin
                  if (fill_ff >= LW'(TABLE_DEPTH)) begin
                     stat_ff <= ST_FULL;
                     st_ff   <= S_EMIT;
                  end else begin
                     vert_mem[fill_ff[AW-1:0]] <= {cur.lo, cur.mid, cur.hi};
                     mark_mem[fill_ff[AW-1:0]] <= {cur.flip, HitBits'(1)};
                     fill_ff <= fill_ff + LW'(1);
                     bnd_ff  <= bnd_ff + LW'(1);
                     st_ff   <= S_NEXT;
                  end
               end else begin
                  st_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               if (vrd_ff == {cur.lo, cur.mid, cur.hi}) begin
                  if (cnt_cur != {HitBits{1'b1}}) begin
                     if (cnt_cur == HitBits'(1) && bnd_ff != '0)
                        bnd_ff <= bnd_ff - LW'(1);
                     mark_mem[raddr] <= {mrd_ff[HitBits], cnt_cur + HitBits'(1)};
                  end
                  st_ff <= S_NEXT;
               end else begin
                  scan_ff <= scan_ff + LW'(1);
                  st_ff   <= S_PROBE;
               end
            end
            S_NEXT: begin
               scan_ff <= '0;
               if (face_ff == 2'd3) begin
                  st_ff <= S_EMIT;
               end else begin
                  face_ff <= face_ff + 2'd1;
                  st_ff   <= S_PROBE;
               end
            end
            S_RDWAIT: st_ff <= S_RDOUT;
            S_RDOUT: st_ff <= S_EMIT;
            S_EMIT: begin
               if (emit_go) begin
                  rsp_ff.status         <= stat_ff;
                  rsp_ff.entries_used   <= CountBits'(fill_ff);
                  rsp_ff.boundary_total <= CountBits'(bnd_ff);
                  if (job_ff.command == CMD_READ && stat_ff == ST_OK) begin
                     rsp_ff.face_low    <= vrd_ff[VW-1 -: FieldBits];
                     rsp_ff.face_mid    <= vrd_ff[2*FieldBits-1 -: FieldBits];
                     rsp_ff.face_high   <= vrd_ff[FieldBits-1:0];
                     rsp_ff.flipped     <= mrd_ff[HitBits];
                     rsp_ff.hit_count   <= cnt_cur;
                     rsp_ff.is_boundary <= (cnt_cur == HitBits'(1));
                  end else begin
                     rsp_ff.face_low    <= '0;
                     rsp_ff.face_mid    <= '0;
                     rsp_ff.face_high   <= '0;
                     rsp_ff.flipped     <= 1'b0;
                     rsp_ff.hit_count   <= '0;
                     rsp_ff.is_boundary <= 1'b0;
                  end
                  st_ff <= S_IDLE;
               end
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

endmodule

/* bench/tb_boundary_face_table.sv */
// Self-checking bench for boundary_face_table: queue-style driver and monitor
// with a behavioral face table model. Depends on bft_pkg and the RTL top.
// Covers directed corner cases and random traffic with stalls.
module tb_boundary_face_table;
   import bft_pkg::*;

   localparam int Depth      = 1024;
   localparam int HitMax     = 15;
   localparam int CycleLimit = 30000000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    push  = 1'b0;
   logic    pop   = 1'b0;
   logic    full, empty;
   req_type req_data = '0;
   rsp_type rsp_data;

   boundary_face_table u_top (
      .clock(clock), .reset(reset),
      .push(push), .full(full), .req_data(req_data),
      .empty(empty), .pop(pop), .rsp_data(rsp_data)
   );

   always #4 clock = ~clock;

   // model state of the face table
   logic [FieldBits-1:0] tbl_lo [Depth];
   logic [FieldBits-1:0] tbl_mid[Depth];
   logic [FieldBits-1:0] tbl_hi [Depth];
   logic                 tbl_flip[Depth];
   logic [HitBits-1:0]   tbl_hits[Depth];
   int                   fill_cnt = 0;
   int                   bnd_cnt  = 0;

   req_type pending_words[$];
   rsp_type expected_rsp[$];
   int      errors = 0;
   int      n_add = 0, n_read = 0, n_clear = 0, n_full = 0, n_checked = 0;
   int      tx_gap = 0, rx_stall = 0;
   bit      long_hold_done = 0;
   longint  cycles = 0;

   function automatic int pick_gap();
      if ($urandom_range(0, 9) < 6) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(20, 80);
   endfunction

   // insert one face; returns 0 when the table has no room for a new face
   function automatic bit insert_face(logic [FieldBits-1:0] p, logic [FieldBits-1:0] q,
                                      logic [FieldBits-1:0] r, logic hand);
      logic [FieldBits-1:0] v[3];
      logic [FieldBits-1:0] t;
      logic par;
      par = hand;
      v[0] = p; v[1] = q; v[2] = r;
      // bubble order, swapping on ties too
      for (int span = 3; span > 1; span--)
         for (int k = 1; k < span; k++)
            if (!(v[k-1] < v[k])) begin
               t = v[k-1]; v[k-1] = v[k]; v[k] = t; par = ~par;
            end
      for (int i = 0; i < fill_cnt; i++)
         if (tbl_lo[i] == v[0] && tbl_mid[i] == v[1] && tbl_hi[i] == v[2]) begin
            if (tbl_hits[i] < HitMax) begin
               if (tbl_hits[i] == 1 && bnd_cnt > 0) bnd_cnt--;
               tbl_hits[i]++;
            end
            return 1;
         end
      if (fill_cnt >= Depth) return 0;
      tbl_lo[fill_cnt] = v[0]; tbl_mid[fill_cnt] = v[1]; tbl_hi[fill_cnt] = v[2];
      tbl_flip[fill_cnt] = par;
      tbl_hits[fill_cnt] = HitBits'(1);
      fill_cnt++;
      bnd_cnt++;
      return 1;
   endfunction

   task automatic predict_face_table(input req_type w);
      rsp_type r;
      bit ok;
      r = '0;
      r.status = ST_OK;
      case (w.command)
         CMD_CLEAR: begin
            fill_cnt = 0; bnd_cnt = 0; n_clear++;
         end
         CMD_ADD: begin
            n_add++;
            ok = insert_face(w.corner_d, w.corner_c, w.corner_b, w.left_hand)
              && insert_face(w.corner_a, w.corner_c, w.corner_d, w.left_hand)
              && insert_face(w.corner_a, w.corner_d, w.corner_b, w.left_hand)
              && insert_face(w.corner_a, w.corner_b, w.corner_c, w.left_hand);
            if (!ok) begin r.status = ST_FULL; n_full++; end
         end
         CMD_READ: begin
            n_read++;
            if (w.entry_index >= fill_cnt) r.status = ST_OOR;
            else begin
               r.face_low    = tbl_lo[w.entry_index];
               r.face_mid    = tbl_mid[w.entry_index];
               r.face_high   = tbl_hi[w.entry_index];
               r.flipped     = tbl_flip[w.entry_index];
               r.hit_count   = tbl_hits[w.entry_index];
               r.is_boundary = (tbl_hits[w.entry_index] == 1);
            end
         end
         default: ;
      endcase
      r.entries_used   = fill_cnt[CountBits-1:0];
      r.boundary_total = bnd_cnt[CountBits-1:0];
      expected_rsp.push_back(r);
   endtask

   task automatic cmp_field(input string name, input int unsigned exp_v,
                            input int unsigned act_v);
      if (exp_v != act_v) begin
         errors++;
         $display("%0t: mismatch %s expected %0h actual %0h", $time, name, exp_v, act_v);
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) predict_face_table(req_data);
         if (!push || !full) begin
            if (tx_gap > 0) begin
               tx_gap <= tx_gap - 1;
               push   <= 1'b0;
            end else if (pending_words.size() > 0) begin
               req_data <= pending_words.pop_front();
               push     <= 1'b1;
               tx_gap   <= pick_gap();
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            n_checked++;
            if (expected_rsp.size() == 0) begin
               errors++;
               $display("%0t: unexpected word, actual %h", $time, rsp_data);
            end else begin
               rsp_type e;
               e = expected_rsp.pop_front();
               cmp_field("status", e.status, rsp_data.status);
               cmp_field("face_low", e.face_low, rsp_data.face_low);
               cmp_field("face_mid", e.face_mid, rsp_data.face_mid);
               cmp_field("face_high", e.face_high, rsp_data.face_high);
               cmp_field("flipped", e.flipped, rsp_data.flipped);
               cmp_field("hit_count", e.hit_count, rsp_data.hit_count);
               cmp_field("is_boundary", e.is_boundary, rsp_data.is_boundary);
               cmp_field("entries_used", e.entries_used, rsp_data.entries_used);
               cmp_field("boundary_total", e.boundary_total, rsp_data.boundary_total);
            end
         end
         if (!long_hold_done && n_checked == 30) begin
            // long hold so the job queue backs up into full
            long_hold_done <= 1'b1;
            rx_stall <= 3000;
            pop      <= 1'b0;
         end else if (rx_stall > 0) begin
            rx_stall <= rx_stall - 1;
            pop      <= 1'b0;
         end else begin
            pop      <= 1'b1;
            rx_stall <= pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("** boundary_face_table: FAILED **");
         $finish;
      end
   end

   function automatic req_type mk_word(logic [1:0] cmd, int unsigned a, int unsigned b,
                                       int unsigned c, int unsigned d, int unsigned lh,
                                       int unsigned idx);
      req_type w;
      w.command = cmd;
      w.corner_a = FieldBits'(a); w.corner_b = FieldBits'(b);
      w.corner_c = FieldBits'(c); w.corner_d = FieldBits'(d);
      w.left_hand = lh[0];
      w.entry_index = IndexBits'(idx);
      return w;
   endfunction

   function automatic int unsigned rand_corner();
      if ($urandom_range(0, 9) < 8) return $urandom_range(0, 9);
      return $urandom_range(0, (1 << FieldBits) - 1);
   endfunction

   function automatic req_type rand_word();
      req_type w;
      int unsigned sel;
      w = mk_word(CMD_ADD, rand_corner(), rand_corner(), rand_corner(), rand_corner(),
                  $urandom_range(0, 1), $urandom_range(0, 15));
      sel = $urandom_range(0, 99);
      if (sel < 4) w.command = CMD_CLEAR;
      else if (sel < 8) w.command = 2'd3;
      else if (sel < 45) w.command = CMD_READ;
      if ($urandom_range(0, 9) == 0)
         w.entry_index = IndexBits'($urandom_range(0, (1 << IndexBits) - 1));
      return w;
   endfunction

   task automatic drain();
      wait (pending_words.size() == 0 && !push && expected_rsp.size() == 0);
      repeat (20) @(posedge clock);
   endtask

   localparam int unsigned VMax = (1 << FieldBits) - 1;

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed
      pending_words.push_back(mk_word(CMD_CLEAR, 0, 0, 0, 0, 0, 0));
      pending_words.push_back(mk_word(CMD_READ, 0, 0, 0, 0, 0, 0));
      pending_words.push_back(mk_word(CMD_ADD, 0, 0, 0, 0, 0, 0));
      pending_words.push_back(mk_word(CMD_ADD, VMax, VMax, VMax, VMax, 1, VMax));
      pending_words.push_back(mk_word(CMD_ADD, 1, 2, 3, 4, 1, 0));
      pending_words.push_back(mk_word(CMD_ADD, 4, 3, 2, 1, 0, 0));
      for (int i = 0; i < 14; i++)
         pending_words.push_back(mk_word(CMD_ADD, 1, 2, 3, 4, 0, 0));
      for (int i = 0; i < 4; i++)
         pending_words.push_back(mk_word(CMD_READ, 0, 0, 0, 0, 0, i + 2));
      pending_words.push_back(mk_word(2'd3, VMax, VMax, VMax, VMax, 1, 1023));
      pending_words.push_back(mk_word(CMD_READ, 0, 0, 0, 0, 0, 1023));
      drain();

      for (int i = 0; i < 57; i++) pending_words.push_back(rand_word());
      drain();
      for (int i = 0; i < 57; i++) pending_words.push_back(rand_word());
      drain();
      repeat (50) @(posedge clock);

      $display("run covered %0d adds (%0d hit a full table), %0d reads, %0d clears",
               n_add, n_full, n_read, n_clear);
      $display("%0d response words checked, %0d mismatches", n_checked, errors);
      if (errors == 0 && expected_rsp.size() == 0)
         $display("** boundary_face_table: PASSED **");
      else
         $display("** boundary_face_table: FAILED **");
      $finish;
   end

endmodule

/* files.f */
rtl/bft_pkg.sv
rtl/bft_front.sv
rtl/bft_back.sv
rtl/boundary_face_table.sv
bench/tb_boundary_face_table.sv
